[src/wsfr_pkg.sv]
// Package: constants, types and CRC function for the wheel speed frame receiver
`default_nettype none
package wsfr_pkg;

   localparam int unsigned FRAME_LEN = 13;
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned WORD_W    = 32;
   localparam int unsigned POS_W     = 4;
   localparam int unsigned LANE_W    = 2;
   localparam int unsigned ADDR_W    = 3;
   localparam int unsigned DATA_W    = 32;

   typedef logic [POS_W-1:0]  pos_type;
   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [WORD_W-1:0] word_type;

   localparam byte_type CRC_POLY      = 8'h8C;
   localparam byte_type HEADER_RESET  = 8'h88;
   localparam byte_type TRAILER_RESET = 8'h66;

   localparam pos_type POS_HEADER_LAST  = 4'd1;
   localparam pos_type POS_LEFT_FIRST   = 4'd2;
   localparam pos_type POS_LEFT_LAST    = 4'd5;
   localparam pos_type POS_RIGHT_FIRST  = 4'd6;
   localparam pos_type POS_RIGHT_LAST   = 4'd9;
   localparam pos_type POS_CRC          = 4'd10;
   localparam pos_type POS_TRAILER_HEAD = 4'd11;
   localparam pos_type POS_LAST         = pos_type'(FRAME_LEN - 1);

   localparam logic REG_HEADER  = 1'b0;
   localparam logic REG_TRAILER = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_HEADER_ERR  = 2'd1,
      STATUS_TRAILER_ERR = 2'd2,
      STATUS_CRC_ERR     = 2'd3
   } status_type;

   typedef struct packed {
      byte_type header_value;
      byte_type trailer_value;
   } cfg_type;

   function automatic byte_type crc8_byte(input byte_type crc, input byte_type b);
      byte_type c;
      c = crc ^ b;
      for (int k = 0; k < BYTE_W; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

[src/wsfr_if.sv]
// Interfaces: byte input channel and frame result channel
`default_nettype none
interface wsfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface wsfr_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] left_speed_bits;
   logic [31:0] right_speed_bits;

   modport source (output valid, output status, output left_speed_bits,
                   output right_speed_bits, input ready);
   modport sink (input valid, input status, input left_speed_bits,
                 input right_speed_bits, output ready);
endinterface
`default_nettype wire

[src/wsfr_csr.sv]
// Configuration registers: header and trailer match values behind an APB-style port
`default_nettype none
module wsfr_csr
   import wsfr_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0] pwdata,
   output logic      [DATA_W-1:0] prdata,
   output logic                   pready,
   output cfg_type                cfg
);

   byte_type header_ff, header_in;
   byte_type trailer_ff, trailer_in;
   logic     wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      header_in  = header_ff;
      trailer_in = trailer_ff;
      if (wr_en) begin
         unique case (paddr[2])
            REG_HEADER:  header_in  = pwdata[BYTE_W-1:0];
            REG_TRAILER: trailer_in = pwdata[BYTE_W-1:0];
            default:     ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_HEADER:  prdata = {{(DATA_W-BYTE_W){1'b0}}, header_ff};
         REG_TRAILER: prdata = {{(DATA_W-BYTE_W){1'b0}}, trailer_ff};
         default:     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff  <= HEADER_RESET;
         trailer_ff <= TRAILER_RESET;
      end else begin
         header_ff  <= header_in;
         trailer_ff <= trailer_in;
      end
   end

   assign cfg.header_value  = header_ff;
   assign cfg.trailer_value = trailer_ff;

endmodule
`default_nettype wire

[src/wsfr_frame.sv]
// Frame datapath: input byte register, frame state, CRC, checks and result register
`default_nettype none
module wsfr_frame
   import wsfr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   wsfr_req_if.sink     req_chan,
   wsfr_rsp_if.source   rsp_chan
);

   logic       in_valid_ff, in_valid_in;
   byte_type   in_byte_ff, in_byte_in;
   pos_type    pos_ff, pos_in;
   byte_type   crc_ff, crc_in;
   word_type   left_ff, left_in;
   word_type   right_ff, right_in;
   logic       header_bad_ff, header_bad_in;
   logic       crc_bad_ff, crc_bad_in;
   logic       trailer_bad_ff, trailer_bad_in;
   logic       out_valid_ff, out_valid_in;
   status_type status_ff, status_in;
   word_type   out_left_ff, out_left_in;
   word_type   out_right_ff, out_right_in;

   pos_type           pos;
   logic              last;
   logic              advance;
   logic              req_fire;
   logic              trailer_bad;
   logic [LANE_W-1:0] left_lane;
   logic [LANE_W-1:0] right_lane;

   assign pos        = (pos_ff > POS_LAST) ? '0 : pos_ff;
   assign last       = (pos == POS_LAST);
   assign advance    = in_valid_ff && (!last || !out_valid_ff || rsp_chan.ready);
   assign req_fire   = req_chan.valid && req_chan.ready;
   assign left_lane  = LANE_W'(pos - POS_LEFT_FIRST);
   assign right_lane = LANE_W'(pos - POS_RIGHT_FIRST);
   assign trailer_bad = trailer_bad_ff || (in_byte_ff != cfg.trailer_value);

   assign req_chan.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_chan.rx_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      pos_in         = pos_ff;
      crc_in         = crc_ff;
      left_in        = left_ff;
      right_in       = right_ff;
      header_bad_in  = header_bad_ff;
      crc_bad_in     = crc_bad_ff;
      trailer_bad_in = trailer_bad_ff;
      if (advance) begin
         if (pos <= POS_RIGHT_LAST) begin
            crc_in = crc8_byte(crc_ff, in_byte_ff);
         end
         if (pos <= POS_HEADER_LAST) begin
            if (in_byte_ff != cfg.header_value) begin
               header_bad_in = 1'b1;
            end
         end else if (pos <= POS_LEFT_LAST) begin
            left_in[BYTE_W*left_lane +: BYTE_W] = in_byte_ff;
         end else if (pos <= POS_RIGHT_LAST) begin
            right_in[BYTE_W*right_lane +: BYTE_W] = in_byte_ff;
         end else if (pos == POS_CRC) begin
            crc_bad_in = (in_byte_ff != crc_ff);
         end else if (pos == POS_TRAILER_HEAD) begin
            trailer_bad_in = (in_byte_ff != cfg.trailer_value);
         end
         if (last) begin
            pos_in         = '0;
            crc_in         = '0;
            header_bad_in  = 1'b0;
            crc_bad_in     = 1'b0;
            trailer_bad_in = 1'b0;
         end else begin
            pos_in = pos + 4'd1;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      status_in    = status_ff;
      out_left_in  = out_left_ff;
      out_right_in = out_right_ff;
      if (advance && last) begin
         out_valid_in = 1'b1;
         if (header_bad_ff) begin
            status_in = STATUS_HEADER_ERR;
         end else if (trailer_bad) begin
            status_in = STATUS_TRAILER_ERR;
         end else if (crc_bad_ff) begin
            status_in = STATUS_CRC_ERR;
         end else begin
            status_in = STATUS_OK;
         end
         out_left_in  = (status_in == STATUS_OK) ? left_ff : '0;
         out_right_in = (status_in == STATUS_OK) ? right_ff : '0;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         pos_ff         <= '0;
         crc_ff         <= '0;
         left_ff        <= '0;
         right_ff       <= '0;
         header_bad_ff  <= 1'b0;
         crc_bad_ff     <= 1'b0;
         trailer_bad_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         in_valid_ff    <= in_valid_in;
         pos_ff         <= pos_in;
         crc_ff         <= crc_in;
         left_ff        <= left_in;
         right_ff       <= right_in;
         header_bad_ff  <= header_bad_in;
         crc_bad_ff     <= crc_bad_in;
         trailer_bad_ff <= trailer_bad_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff   <= in_byte_in;
      status_ff    <= status_in;
      out_left_ff  <= out_left_in;
      out_right_ff <= out_right_in;
   end

   assign rsp_chan.valid            = out_valid_ff;
   assign rsp_chan.status           = 2'(status_ff);
   assign rsp_chan.left_speed_bits  = out_left_ff;
   assign rsp_chan.right_speed_bits = out_right_ff;

`ifndef SYNTH
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_LAST)
      else $error("frame position out of range");

   a_wrap: assert property (@(posedge clock) disable iff (reset)
      (advance && last) |=> (pos_ff == '0 && crc_ff == '0 && !header_bad_ff))
      else $error("frame state not cleared after last beat");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      (!out_valid_ff ##1 out_valid_ff) |-> $past(in_valid_ff && last))
      else $error("result raised without a closing beat");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && status_ff != STATUS_OK) |-> (out_left_ff == '0 && out_right_ff == '0))
      else $error("failed frame carries speed data");
`endif

endmodule
`default_nettype wire

[src/wheel_speed_frame_receiver_unit.sv]
// Top level: wheel speed frame receiver with configuration registers
// Throughput: one byte beat per cycle, sustained, while the result side keeps up.
// Result path: a frame's last byte beat is taken into the input byte register, then its
//   result is written to the result register.
// A stalled result holds only the closing beat of the next frame; other beats keep flowing.
// Reset (synchronous, active high): clears frame position, CRC, flags and pending beats;
//   header and trailer match registers return to 0x88 and 0x66.
`default_nettype none
module wheel_speed_frame_receiver_unit
   import wsfr_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   wsfr_req_if.sink               req_chan,
   wsfr_rsp_if.source             rsp_chan,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0] pwdata,
   output logic      [DATA_W-1:0] prdata,
   output logic                   pready
);

   cfg_type cfg;

   wsfr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   wsfr_frame u_frame (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule
`default_nettype wire
